### hw/rtl/cll_pkg.sv
// Shared constants, codes and item types of the circular list with cursor.
package cll_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int ACT_BITS   = 3;
    localparam int STEP_BITS  = 8;
    localparam int STAT_BITS  = 2;

    localparam logic [ACT_BITS-1:0] ACT_INS_LEFT  = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_INS_RIGHT = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_SEARCH    = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_REMOVE    = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_ADVANCE   = 3'd4;

    localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_BITS-1:0] STAT_FULL      = 2'd3;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [ACT_BITS-1:0]         action;
        logic                        clear_request;
        t_value                      item_value;
        logic signed [STEP_BITS-1:0] step_count;
    } t_in_item;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        t_value               cursor_value;
        t_count               entry_count;
    } t_out_item;

    typedef struct packed {
        t_slot next_slot;
        t_slot prev_slot;
    } t_link;

    typedef struct packed {
        logic  en_next;
        logic  en_prev;
        t_slot addr;
        t_link data;
    } t_link_wr;

    typedef struct packed {
        logic  clear_all;
        logic  take;
        t_slot take_slot;
        logic  give_back;
        t_slot give_slot;
    } t_free_cmd;

    typedef struct packed {
        logic                full;
        t_slot               first_free;
        logic [CAPACITY-1:0] in_use;
    } t_free_stat;

endpackage

### hw/rtl/cll_value_mem.sv
// Slot value memory: one write port, one registered read port.
module cll_value_mem import cll_pkg::*; (
    input  logic   i_clk,
    input  logic   i_wr_en,
    input  t_slot  i_wr_addr,
    input  t_value i_wr_data,
    input  t_slot  i_rd_addr,
    output t_value o_rd_data
);

    t_value r_mem [CAPACITY];
    t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cll_link_mem.sv
// Link memory: next and prev slot per entry, field write enables, registered read.
module cll_link_mem import cll_pkg::*; (
    input  logic     i_clk,
    input  t_link_wr i_wr,
    input  t_slot    i_rd_addr,
    output t_link    o_rd_data
);

    t_link r_mem [CAPACITY];
    t_link r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en_next) begin
            r_mem[i_wr.addr].next_slot <= i_wr.data.next_slot;
        end
        if (i_wr.en_prev) begin
            r_mem[i_wr.addr].prev_slot <= i_wr.data.prev_slot;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cll_free_map.sv
// Free map: slot in-use bits and lowest free slot.
module cll_free_map import cll_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_free_cmd  i_cmd,
    output t_free_stat o_stat
);

    logic [CAPACITY-1:0] r_in_use;
    logic [CAPACITY-1:0] n_in_use;
    t_slot               first_free;

    always_comb begin
        n_in_use = r_in_use;
        if (i_cmd.clear_all) begin
            n_in_use = '0;
        end else begin
            if (i_cmd.take) begin
                n_in_use[i_cmd.take_slot] = 1'b1;
            end
            if (i_cmd.give_back) begin
                n_in_use[i_cmd.give_slot] = 1'b0;
            end
        end
    end

    always_comb begin
        first_free = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                first_free = t_slot'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else begin
            r_in_use <= n_in_use;
        end
    end

    assign o_stat.full       = &r_in_use;
    assign o_stat.first_free = first_free;
    assign o_stat.in_use     = r_in_use;

endmodule

### hw/rtl/circular_list_with_cursor.sv
// Top level: circular doubly linked list with cursor, sequencer over slot memories.
//
//   channel | dir | handshake                  | payload
//   in      | in  | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//   out     | out | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
// One item at a time. A taken item is decoded; an insert into a nonempty list then
// writes neighbour, new entry and cursor links in turn; search and remove visit the
// entries one by one (up to 16), a remove from a longer list then fixes the next
// entry's prev link, and advance walks |step_count| links: the single read port of
// the link memory walks one link per cycle. Reset clears free map and cursor state.
// One finished result waits in the output register; the next item is taken meanwhile.
module circular_list_with_cursor import cll_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_INS_LINK = 4'd2;
    localparam logic [3:0] S_INS_NEW  = 4'd3;
    localparam logic [3:0] S_INS_CUR  = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_RM_FIX   = 4'd6;
    localparam logic [3:0] S_ADV      = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;

    logic [3:0]                  r_state, n_state;
    t_in_item                    r_item, n_item;
    t_slot                       r_cur, n_cur;
    logic                        r_nonempty, n_nonempty;
    t_count                      r_count, n_count;
    t_slot                       r_walk, n_walk;
    t_count                      r_k, n_k;
    logic signed [STEP_BITS-1:0] r_steps, n_steps;
    logic [STAT_BITS-1:0]        r_status, n_status;
    t_slot                       r_new, n_new;
    t_slot                       r_nb, n_nb;
    logic                        r_out_valid, n_out_valid;
    t_out_item                   r_out_item, n_out_item;

    t_slot      rd_addr;
    logic       val_we;
    t_value     val_rd;
    t_link      link_rd;
    t_link_wr   link_wr;
    t_free_cmd  free_cmd;
    t_free_stat free_stat;
    logic       to_right;
    t_slot      adv_slot;

    cll_value_mem u_value_mem (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (free_stat.first_free),
        .i_wr_data (r_item.item_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (val_rd)
    );

    cll_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_wr      (link_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rd)
    );

    cll_free_map u_free_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (free_cmd),
        .o_stat  (free_stat)
    );

    assign to_right = (r_item.action == ACT_INS_RIGHT);
    assign adv_slot = (r_steps > 0) ? link_rd.next_slot : link_rd.prev_slot;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cur       = r_cur;
        n_nonempty  = r_nonempty;
        n_count     = r_count;
        n_walk      = r_walk;
        n_k         = r_k;
        n_steps     = r_steps;
        n_status    = r_status;
        n_new       = r_new;
        n_nb        = r_nb;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        rd_addr     = r_cur;
        val_we      = 1'b0;
        link_wr     = '0;
        free_cmd    = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_FIN;
                n_status = STAT_OK;
                if (r_item.clear_request) begin
                    n_status           = r_nonempty ? STAT_OK : STAT_EMPTY;
                    free_cmd.clear_all = 1'b1;
                    n_cur              = '0;
                    n_nonempty         = 1'b0;
                    n_count            = '0;
                end else begin
                    case (r_item.action)
                        ACT_INS_LEFT, ACT_INS_RIGHT: begin
                            if (free_stat.full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_new              = free_stat.first_free;
                                free_cmd.take      = 1'b1;
                                free_cmd.take_slot = free_stat.first_free;
                                val_we             = 1'b1;
                                if (!r_nonempty) begin
                                    link_wr.en_next        = 1'b1;
                                    link_wr.en_prev        = 1'b1;
                                    link_wr.addr           = free_stat.first_free;
                                    link_wr.data.next_slot = free_stat.first_free;
                                    link_wr.data.prev_slot = free_stat.first_free;
                                    n_cur                  = free_stat.first_free;
                                    n_nonempty             = 1'b1;
                                    n_count                = r_count + 1'b1;
                                end else begin
                                    n_state = S_INS_LINK;
                                end
                            end
                        end
                        ACT_SEARCH, ACT_REMOVE: begin
                            if (!r_nonempty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_walk  = r_cur;
                                n_k     = '0;
                                n_state = S_WALK;
                            end
                        end
                        ACT_ADVANCE: begin
                            if (!r_nonempty) begin
                                n_status = STAT_EMPTY;
                            end else if (r_item.step_count != '0) begin
                                n_steps = r_item.step_count;
                                n_state = S_ADV;
                            end
                        end
                        default: begin
                            n_status = r_nonempty ? STAT_OK : STAT_EMPTY;
                        end
                    endcase
                end
            end
            S_INS_LINK: begin
                link_wr.addr = to_right ? link_rd.next_slot : link_rd.prev_slot;
                n_nb         = link_wr.addr;
                if (to_right) begin
                    link_wr.en_prev        = 1'b1;
                    link_wr.data.prev_slot = r_new;
                end else begin
                    link_wr.en_next        = 1'b1;
                    link_wr.data.next_slot = r_new;
                end
                n_state = S_INS_NEW;
            end
            S_INS_NEW: begin
                link_wr.en_next        = 1'b1;
                link_wr.en_prev        = 1'b1;
                link_wr.addr           = r_new;
                link_wr.data.next_slot = to_right ? r_nb : r_cur;
                link_wr.data.prev_slot = to_right ? r_cur : r_nb;
                n_state                = S_INS_CUR;
            end
            S_INS_CUR: begin
                link_wr.addr = r_cur;
                if (to_right) begin
                    link_wr.en_next        = 1'b1;
                    link_wr.data.next_slot = r_new;
                end else begin
                    link_wr.en_prev        = 1'b1;
                    link_wr.data.prev_slot = r_new;
                end
                n_cur      = r_new;
                n_nonempty = 1'b1;
                n_count    = r_count + 1'b1;
                n_state    = S_FIN;
            end
            S_WALK: begin
                if (val_rd == r_item.item_value) begin
                    n_status = STAT_OK;
                    n_state  = S_FIN;
                    n_cur    = r_walk;
                    if (r_item.action == ACT_REMOVE) begin
                        if (link_rd.prev_slot == r_walk) begin
                            free_cmd.clear_all = 1'b1;
                            n_cur              = '0;
                            n_nonempty         = 1'b0;
                            n_count            = '0;
                        end else begin
                            link_wr.en_next        = 1'b1;
                            link_wr.addr           = link_rd.prev_slot;
                            link_wr.data.next_slot = link_rd.next_slot;
                            n_nb                   = link_rd.next_slot;
                            n_new                  = link_rd.prev_slot;
                            free_cmd.give_back     = 1'b1;
                            free_cmd.give_slot     = r_walk;
                            n_count                = r_count - 1'b1;
                            n_cur                  = link_rd.prev_slot;
                            n_state                = S_RM_FIX;
                        end
                    end
                end else if (t_count'(r_k + 1'b1) >= r_count) begin
                    n_status = STAT_NOT_FOUND;
                    n_state  = S_FIN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_walk  = link_rd.next_slot;
                    rd_addr = link_rd.next_slot;
                end
            end
            S_RM_FIX: begin
                link_wr.en_prev        = 1'b1;
                link_wr.addr           = r_nb;
                link_wr.data.prev_slot = r_new;
                n_state                = S_FIN;
            end
            S_ADV: begin
                n_steps = (r_steps > 0) ? r_steps - STEP_BITS'(1) : r_steps + STEP_BITS'(1);
                if (n_steps == '0) begin
                    n_cur   = adv_slot;
                    n_state = S_FIN;
                end else begin
                    rd_addr = adv_slot;
                end
            end
            S_FIN: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_item.status       = r_status;
                    n_out_item.cursor_value = r_nonempty ? val_rd : '0;
                    n_out_item.entry_count  = r_count;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_nonempty  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_nonempty  <= n_nonempty;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_walk     <= n_walk;
        r_k        <= n_k;
        r_steps    <= n_steps;
        r_status   <= n_status;
        r_new      <= n_new;
        r_nb       <= n_nb;
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_nonempty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nonempty == (r_count != '0))
        else $error("nonempty flag disagrees with entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count above capacity");

    a_free_map_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(free_stat.in_use) == int'(r_count)))
        else $error("free map disagrees with entry count");

    a_cursor_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_nonempty) |-> free_stat.in_use[r_cur])
        else $error("cursor points at a free slot");

endmodule
